>>> rtl/runge_kutta_ode_stepper_top_defines.svh
// assertion macros for the ode stepper
`ifndef RUNGE_KUTTA_ODE_STEPPER_TOP_DEFINES_SVH
`define RUNGE_KUTTA_ODE_STEPPER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define RKS_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define RKS_ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define RKS_ASSERT(label, clk, rst_n, prop)
`define RKS_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

>>> rtl/rks_pkg.sv
// shared types and constants of the ode stepper
package rks_pkg;
  localparam int unsigned FracBitsDefault = 16;
  localparam int unsigned WordW = 32;
  localparam int unsigned AccW = 72;
  localparam int unsigned BitCntW = 6;

  typedef enum logic [2:0] {
    ST_IDLE, ST_ALU, ST_MUL, ST_DIV, ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    REG_STEP = 2'd0,
    REG_ORDER = 2'd1
  } reg_idx_e;

  // microcode operations, one per sequencer step
  typedef enum logic [3:0] {
    OP_XT0,     // xt = x, yt = y, clear pass and sum
    OP_SQ,      // m = rnd(xt*xt)          (multiply)
    OP_F,       // f = sat(m - yt); heun keeps s1 on the first pass
    OP_HF,      // m = rnd(h*f, frac)      (multiply)
    OP_K,       // rk4: k = sat(m), weighted sum, next slope point
    OP_YP,      // heun: yt = sat(y + sat(m)), xt = sat(x + h)
    OP_SS,      // heun: f = sat(s1 + f)
    OP_HS,      // heun: m = rnd(h*s, frac+1)  (multiply)
    OP_YNH,     // heun: yn = sat(y + sat(m))
    OP_YN4,     // rk4: start the serial division of the sum by six
    OP_DONE
  } op_e;

  typedef struct packed {
    logic start;
    logic signed [WordW-1:0] a;
    logic signed [WordW-1:0] b;
    logic [BitCntW-1:0] shift;
  } mul_req_t;

  typedef struct packed {
    logic done;
    logic signed [AccW-1:0] p;
  } mul_rsp_t;
endpackage

>>> rtl/rks_if.sv
// valid/ready channel interfaces of the ode stepper
interface rks_in_if;
  logic valid;
  logic ready;
  logic mode;
  logic signed [31:0] x_initial;
  logic signed [31:0] y_initial;
  modport source (output valid, mode, x_initial, y_initial, input ready);
  modport sink (input valid, mode, x_initial, y_initial, output ready);
endinterface

interface rks_out_if;
  logic valid;
  logic ready;
  logic signed [31:0] x_value;
  logic signed [31:0] y_value;
  logic overflow;
  modport source (output valid, x_value, y_value, overflow, input ready);
  modport sink (input valid, x_value, y_value, overflow, output ready);
endinterface

>>> rtl/rks_mul.sv
// bit-serial signed multiplier with rounded right shift
module rks_mul import rks_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mul_req_t req_i,
  output mul_rsp_t rsp_o
);
  logic signed [AccW-1:0] acc_q, acc_d, mc_q, mc_d;
  logic [WordW-1:0] mp_q, mp_d;
  logic [BitCntW-1:0] cnt_q, cnt_d, sh_q, sh_d;
  logic busy_q, busy_d, done_q, done_d;
  logic signed [AccW-1:0] rnd;

  always_comb begin
    acc_d = acc_q;
    mc_d = mc_q;
    mp_d = mp_q;
    cnt_d = cnt_q;
    sh_d = sh_q;
    busy_d = busy_q;
    done_d = 1'b0;
    rnd = '0;
    if (req_i.start) begin
      acc_d = '0;
      mc_d = AccW'(req_i.a);
      mp_d = req_i.b;
      sh_d = req_i.shift;
      cnt_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      // shift-add one multiplier bit per cycle, top bit weighs negative
      if (mp_q[0]) begin
        if (cnt_q == BitCntW'(WordW-1)) acc_d = acc_q - mc_q;
        else acc_d = acc_q + mc_q;
      end
      mc_d = mc_q <<< 1;
      mp_d = mp_q >> 1;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == BitCntW'(WordW-1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        rnd = AccW'(1) <<< (sh_q - 1'b1);
        acc_d = (acc_d + rnd) >>> sh_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    mc_q <= mc_d;
    mp_q <= mp_d;
    sh_q <= sh_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.p = acc_q;
endmodule

>>> rtl/runge_kutta_ode_stepper_top.sv
// top level of the fixed-step ode stepper (heun / rk4) for y' = x*x - y
// usage:
//   in_if  : transactions with mode (0 load point, 1 integrate) and x/y start values
//   out_if : one transaction per input with current x, y and an overflow flag
//   apb    : reg 0 step size h (q format), reg 1 method order (0 heun, 1 rk4)
// sequencing:
//   a load passes through the output state and is then registered as a valid result
//   an integrate step runs a sequencer around one shared bit-serial multiplier:
//   heun does 4 products, rk4 does 8; rk4 adds a serial divide by six;
//   a new input is taken only after the result has left the output register
// reset:
//   x and y clear to zero, h resets to one, order resets to rk4
// stall:
//   a result waits in the output register while the receiver holds ready low;
//   no new transaction is taken until it leaves
`include "runge_kutta_ode_stepper_top_defines.svh"
module runge_kutta_ode_stepper_top import rks_pkg::*; #(
  parameter int unsigned FRAC_BITS = FracBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rks_in_if.sink      in_if,
  rks_out_if.source   out_if,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam logic signed [AccW-1:0] WMax = AccW'(64'sd2147483647);
  localparam logic signed [AccW-1:0] WMin = -AccW'(64'sd2147483648);
  localparam logic [3:0] DivBy = 4'd6;

  state_e state_q, state_d;
  op_e op_q, op_d;
  logic signed [WordW-1:0] h_q, x_q, y_q, xt_q, yt_q, f_q, s1_q;
  logic signed [WordW-1:0] xt_d, yt_d, f_d, s1_d, xn;
  logic signed [AccW-1:0] acc_q, acc_d, xn_wide;
  logic order_q, ov_q, ov_d;
  logic neg_q, neg_d;
  logic [1:0] pass_q, pass_d;
  logic [AccW-1:0] quo_q, quo_d;
  logic [2:0] rem_q, rem_d;
  logic [6:0] dcnt_q, dcnt_d;
  logic signed [WordW-1:0] ox_q, oy_q;
  logic ovo_q, ovalid_q;
  logic [1:0] reg_sel;
  logic wr;
  mul_req_t mreq;
  mul_rsp_t mrsp;
  logic take, load;

  rks_mul u_mul (.clk_i, .rst_ni, .req_i(mreq), .rsp_o(mrsp));

  // saturate a wide value to a word
  function automatic logic signed [WordW-1:0] satw(input logic signed [AccW-1:0] v);
    if (v > WMax) return WordW'(WMax);
    if (v < WMin) return WordW'(WMin);
    return WordW'(v);
  endfunction

  function automatic logic ovfw(input logic signed [AccW-1:0] v);
    return (v > WMax) || (v < WMin);
  endfunction

  assign pready = 1'b1;
  assign reg_sel = paddr[2] ? REG_ORDER : REG_STEP;
  assign wr = psel && penable && pwrite;
  assign prdata = paddr[2] ? {31'b0, order_q} : h_q;

  assign take = in_if.valid && in_if.ready;
  assign load = !in_if.mode;
  assign in_if.ready = (state_q == ST_IDLE) && !ovalid_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (take) state_d = load ? ST_OUT : ST_ALU;
      ST_ALU: begin
        if (op_q == OP_SQ || op_q == OP_HF || op_q == OP_HS) state_d = ST_MUL;
        else if (op_q == OP_YN4) state_d = ST_DIV;
        else if (op_q == OP_DONE) state_d = ST_OUT;
      end
      ST_MUL: if (mrsp.done) state_d = ST_ALU;
      ST_DIV: if (dcnt_q == '0) state_d = ST_ALU;
      ST_OUT: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and microcode
  always_comb begin
    logic signed [WordW-1:0] kv;
    logic signed [AccW-1:0] ysum, xsum, inc;
    logic [3:0] rtry;
    logic [AccW-1:0] quo_n;
    op_d = op_q;
    pass_d = pass_q;
    xt_d = xt_q;
    yt_d = yt_q;
    f_d = f_q;
    s1_d = s1_q;
    acc_d = acc_q;
    ov_d = ov_q;
    neg_d = neg_q;
    quo_d = quo_q;
    rem_d = rem_q;
    dcnt_d = dcnt_q;
    mreq = '0;
    kv = satw(mrsp.p);
    ysum = '0;
    xsum = '0;
    inc = '0;
    rtry = '0;
    quo_n = '0;
    case (state_q)
      ST_IDLE: begin
        if (take && !load) begin
          op_d = OP_XT0;
          ov_d = 1'b0;
        end
      end
      ST_DIV: begin
        // restoring division, one quotient bit per cycle
        rtry = {rem_q, quo_q[AccW-1]};
        if (rtry >= DivBy) begin
          rem_d = 3'(rtry - DivBy);
          quo_n = {quo_q[AccW-2:0], 1'b1};
        end else begin
          rem_d = rtry[2:0];
          quo_n = {quo_q[AccW-2:0], 1'b0};
        end
        quo_d = quo_n;
        dcnt_d = dcnt_q - 1'b1;
        if (dcnt_q == '0) begin
          inc = neg_q ? -$signed(quo_n) : $signed(quo_n);
          ysum = AccW'(y_q) + inc;
          yt_d = satw(ysum);
          ov_d = ov_q | ovfw(ysum);
        end
      end
      ST_ALU: begin
        case (op_q)
          OP_XT0: begin
            xt_d = x_q;
            yt_d = y_q;
            pass_d = '0;
            acc_d = '0;
            op_d = OP_SQ;
          end
          OP_SQ: begin
            mreq.start = 1'b1;
            mreq.a = xt_q;
            mreq.b = xt_q;
            mreq.shift = BitCntW'(FRAC_BITS);
            op_d = OP_F;
          end
          OP_F: begin
            ysum = mrsp.p - AccW'(yt_q);
            f_d = satw(ysum);
            ov_d = ov_q | ovfw(ysum);
            if (order_q) begin
              op_d = OP_HF;
            end else if (pass_q == '0) begin
              s1_d = f_d;
              op_d = OP_HF;
            end else begin
              op_d = OP_SS;
            end
          end
          OP_HF: begin
            mreq.start = 1'b1;
            mreq.a = h_q;
            mreq.b = f_q;
            mreq.shift = BitCntW'(FRAC_BITS);
            op_d = order_q ? OP_K : OP_YP;
          end
          OP_YP: begin
            ysum = AccW'(y_q) + AccW'(kv);
            xsum = AccW'(x_q) + AccW'(h_q);
            yt_d = satw(ysum);
            xt_d = satw(xsum);
            ov_d = ov_q | ovfw(mrsp.p) | ovfw(ysum) | ovfw(xsum);
            pass_d = pass_q + 1'b1;
            op_d = OP_SQ;
          end
          OP_SS: begin
            ysum = AccW'(s1_q) + AccW'(f_q);
            f_d = satw(ysum);
            ov_d = ov_q | ovfw(ysum);
            op_d = OP_HS;
          end
          OP_HS: begin
            mreq.start = 1'b1;
            mreq.a = h_q;
            mreq.b = f_q;
            mreq.shift = BitCntW'(FRAC_BITS + 1);
            op_d = OP_YNH;
          end
          OP_YNH: begin
            ysum = AccW'(y_q) + AccW'(kv);
            yt_d = satw(ysum);
            ov_d = ov_q | ovfw(mrsp.p) | ovfw(ysum);
            op_d = OP_DONE;
          end
          OP_K: begin
            case (pass_q)
              2'd0: begin
                acc_d = AccW'(kv);
                ysum = AccW'(y_q) + (AccW'(kv) >>> 1);
                xsum = AccW'(x_q) + (AccW'(h_q) >>> 1);
              end
              2'd1: begin
                acc_d = acc_q + (AccW'(kv) <<< 1);
                ysum = AccW'(y_q) + (AccW'(kv) >>> 1);
                xsum = AccW'(xt_q);
              end
              2'd2: begin
                acc_d = acc_q + (AccW'(kv) <<< 1);
                ysum = AccW'(y_q) + AccW'(kv);
                xsum = AccW'(x_q) + AccW'(h_q);
              end
              default: begin
                acc_d = acc_q + AccW'(kv);
                ysum = AccW'(yt_q);
                xsum = AccW'(xt_q);
              end
            endcase
            yt_d = satw(ysum);
            xt_d = satw(xsum);
            ov_d = ov_q | ovfw(mrsp.p) | ovfw(ysum) | ovfw(xsum);
            pass_d = pass_q + 1'b1;
            op_d = (pass_q == 2'd3) ? OP_YN4 : OP_SQ;
          end
          OP_YN4: begin
            // round half away from zero: (|sum| + 3) / 6
            neg_d = acc_q[AccW-1];
            quo_d = acc_q[AccW-1] ? AccW'(-acc_q + AccW'(3)) : AccW'(acc_q + AccW'(3));
            rem_d = '0;
            dcnt_d = 7'(AccW - 1);
            op_d = OP_DONE;
          end
          OP_DONE: op_d = OP_DONE;
          default: op_d = OP_DONE;
        endcase
      end
      default: op_d = op_q;
    endcase
  end

  // new x with its own saturation flag
  assign xn_wide = AccW'(x_q) + AccW'(h_q);
  assign xn = satw(xn_wide);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q <= OP_DONE;
      h_q <= WordW'(1) <<< FRAC_BITS;
      order_q <= 1'b1;
      x_q <= '0;
      y_q <= '0;
      ovalid_q <= 1'b0;
      ov_q <= 1'b0;
      dcnt_q <= '0;
    end else begin
      state_q <= state_d;
      op_q <= op_d;
      ov_q <= ov_d;
      dcnt_q <= dcnt_d;
      if (wr && reg_sel == REG_STEP) h_q <= pwdata;
      if (wr && reg_sel == REG_ORDER) order_q <= pwdata[0];
      if (take && load) begin
        x_q <= in_if.x_initial;
        y_q <= in_if.y_initial;
      end
      if (state_q == ST_ALU && op_q == OP_DONE) begin
        x_q <= xn;
        y_q <= yt_q;
      end
      if (state_q == ST_OUT) ovalid_q <= 1'b1;
      else if (out_if.ready) ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    xt_q <= xt_d;
    yt_q <= yt_d;
    f_q <= f_d;
    s1_q <= s1_d;
    acc_q <= acc_d;
    pass_q <= pass_d;
    neg_q <= neg_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (take && load) ovo_q <= 1'b0;
    if (state_q == ST_ALU && op_q == OP_DONE) ovo_q <= ov_q | ovfw(xn_wide);
    if (state_q == ST_OUT) begin
      ox_q <= x_q;
      oy_q <= y_q;
    end
  end

  assign out_if.valid = ovalid_q;
  assign out_if.x_value = ox_q;
  assign out_if.y_value = oy_q;
  assign out_if.overflow = ovo_q;

  `RKS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_if.valid && !out_if.ready, out_if.valid)
  `RKS_ASSERT(a_no_take_busy, clk_i, rst_ni, (state_q != ST_IDLE) |-> !in_if.ready)
  `RKS_ASSERT_NEXT(a_load_out, clk_i, rst_ni, take && load, state_q == ST_OUT)
endmodule
